>>> rtl/core/sprp_pkg.sv
// Shared types for the strong probable prime test core.
// Holds controller states, datapath operation codes and the status struct.
// No dependencies.
package sprp_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRE, ST_GCD, ST_RED, ST_SPLIT, ST_EXP_SQ, ST_MUL_SQ, ST_EXP_BIT,
    ST_MUL_B, ST_EXP_NEXT, ST_CHECK, ST_MUL_S, ST_CHECK_S, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GCD, OP_RED, OP_SPLIT, OP_EXP_INIT, OP_SQ_X,
    OP_MUL_B, OP_MUL_STEP, OP_EBIT_DEC, OP_SQ_LOOP
  } op_t;

  typedef struct packed {
    logic n_small;
    logic both_even;
    logic gcd_done;
    logic coprime;
    logic cnt_zero;
    logic d_even;
    logic ebit;
    logic ecnt_zero;
    logic x_one;
    logic x_nm1;
    logic s_gt1;
  } dp_sts_t;

endpackage

>>> rtl/core/strong_probable_prime_test_core.sv
// Top level of the strong probable prime test core (one base).
// Instantiates sprp_ctrl and sprp_dp and holds the result register.
//
//   channel | dir | tdata fields (low bit first)          | tuser/tlast
//   in_     | in  | candidate[W-1:0], base[W-1:0], zeros   | none
//   out_    | out | probable_prime, zeros to 8 bits        | none
//
// One item at a time. The exponentiation runs one modular squaring for each
// of the W bit positions of d and one multiply by the base for each set bit;
// the squaring loop, the base reduction and the gcd steps come on top of it.
// The modular multiplier is bit-serial, taking one operand bit a cycle.
// Reset is synchronous, active low; a new item is taken while a finished
// result waits in the output register for out_tready.
module strong_probable_prime_test_core #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // candidate, then base, then zero padding
  input  logic [((2*NUMBER_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // probable_prime, then zero padding
  output logic [7:0]                                out_tdata
);

  localparam int W = NUMBER_WIDTH;

  sprp_pkg::op_t     op;
  sprp_pkg::dp_sts_t sts;
  logic              slot_free, res_push, res_bit;
  logic              out_valid_r, out_valid_nxt;
  logic              out_pp_r, out_pp_nxt;

  sprp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .sts       (sts),
    .op        (op),
    .slot_free (slot_free),
    .res_push  (res_push),
    .res_bit   (res_bit)
  );

  sprp_dp #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk       (clk),
    .op        (op),
    .candidate (in_tdata[W-1:0]),
    .base      (in_tdata[2*W-1:W]),
    .sts       (sts)
  );

  // Output register: load a verdict when empty or being drained
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pp_nxt    = out_pp_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
      out_pp_nxt    = res_bit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_pp_r <= out_pp_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_pp_r};

endmodule

>>> rtl/core/sprp_dp.sv
// Datapath of the strong probable prime test: gcd, base reduction,
// split of n-1, bit-serial modular multiply. Depends on sprp_pkg.
module sprp_dp #(
  parameter int NUMBER_WIDTH = 31
) (
  input  logic                    clk,
  input  sprp_pkg::op_t           op,
  input  logic [NUMBER_WIDTH-1:0] candidate,
  input  logic [NUMBER_WIDTH-1:0] base,
  output sprp_pkg::dp_sts_t       sts
);

  localparam int W  = NUMBER_WIDTH;
  localparam int CW = $clog2(NUMBER_WIDTH);

  logic [W-1:0]  n_r, a_r, b_r, bin_r, base_r, d_r, x_r, mx_r, my_r, acc_r;
  logic [CW-1:0] cnt_r, ecnt_r, s_r;

  logic [W:0]    red_in, red_sub, dbl, dbl_sub, sum, sum_sub;
  logic [W-1:0]  red_out, dbl_mod, acc_mul;

  // Reduction step: shift in one base bit, subtract n at most once
  always_comb begin
    red_in  = {acc_r, bin_r[cnt_r]};
    red_sub = red_in - {1'b0, n_r};
    red_out = (red_in >= {1'b0, n_r}) ? red_sub[W-1:0] : red_in[W-1:0];
  end

  // Multiply step: double the accumulator, then add multiplicand on a set bit
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_sub = dbl - {1'b0, n_r};
    dbl_mod = (dbl >= {1'b0, n_r}) ? dbl_sub[W-1:0] : dbl[W-1:0];
    sum     = {1'b0, dbl_mod} + {1'b0, mx_r};
    sum_sub = sum - {1'b0, n_r};
    if (my_r[cnt_r]) begin
      acc_mul = (sum >= {1'b0, n_r}) ? sum_sub[W-1:0] : sum[W-1:0];
    end else begin
      acc_mul = dbl_mod;
    end
  end

  // Execute the operation the controller issues
  always_ff @(posedge clk) begin
    unique case (op)
      sprp_pkg::OP_LOAD: begin
        n_r   <= candidate;
        a_r   <= candidate;
        b_r   <= base;
        bin_r <= base;
        d_r   <= candidate - W'(1);
        s_r   <= '0;
        acc_r <= '0;
        cnt_r <= CW'(W - 1);
      end
      sprp_pkg::OP_GCD: begin
        priority if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_r >= b_r) begin
          a_r <= a_r - b_r;
        end else begin
          b_r <= b_r - a_r;
        end
      end
      sprp_pkg::OP_RED: begin
        acc_r <= red_out;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          base_r <= red_out;
        end
      end
      sprp_pkg::OP_SPLIT: begin
        d_r <= d_r >> 1;
        s_r <= s_r + CW'(1);
      end
      sprp_pkg::OP_EXP_INIT: begin
        x_r    <= W'(1);
        ecnt_r <= CW'(W - 1);
      end
      sprp_pkg::OP_SQ_X, sprp_pkg::OP_SQ_LOOP: begin
        mx_r  <= x_r;
        my_r  <= x_r;
        acc_r <= '0;
        cnt_r <= CW'(W - 1);
        if (op == sprp_pkg::OP_SQ_LOOP) begin
          s_r <= s_r - CW'(1);
        end
      end
      sprp_pkg::OP_MUL_B: begin
        mx_r  <= base_r;
        my_r  <= x_r;
        acc_r <= '0;
        cnt_r <= CW'(W - 1);
      end
      sprp_pkg::OP_MUL_STEP: begin
        acc_r <= acc_mul;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          x_r <= acc_mul;
        end
      end
      sprp_pkg::OP_EBIT_DEC: begin
        ecnt_r <= ecnt_r - CW'(1);
      end
      default: begin
      end
    endcase
  end

  // Report status to the controller
  always_comb begin
    sts.n_small   = (n_r[W-1:1] == '0);
    sts.both_even = !a_r[0] && !b_r[0];
    sts.gcd_done  = (a_r == '0) || (b_r == '0);
    sts.coprime   = (a_r == '0) ? (b_r == W'(1)) : (a_r == W'(1));
    sts.cnt_zero  = (cnt_r == '0);
    sts.d_even    = !d_r[0];
    sts.ebit      = d_r[ecnt_r];
    sts.ecnt_zero = (ecnt_r == '0);
    sts.x_one     = (x_r == W'(1));
    sts.x_nm1     = (x_r == n_r - W'(1));
    sts.s_gt1     = (s_r > CW'(1));
  end

endmodule

>>> rtl/core/sprp_ctrl.sv
// Controller of the strong probable prime test: sequences gcd, reduction,
// split, exponentiation and squaring loop. Depends on sprp_pkg.
module sprp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sprp_pkg::dp_sts_t sts,
  output sprp_pkg::op_t     op,
  input  logic              slot_free,
  output logic              res_push,
  output logic              res_bit
);

  sprp_pkg::state_t state_r, state_nxt;
  logic             res_r, res_nxt;

  // Hold state and verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sprp_pkg::ST_IDLE;
      res_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res_bit = res_r;

  // Advance the sequence and issue datapath operations
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    op        = sprp_pkg::OP_NONE;
    in_ready  = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      sprp_pkg::ST_IDLE: begin
        // Take no item while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          op        = sprp_pkg::OP_LOAD;
          state_nxt = sprp_pkg::ST_PRE;
        end
      end
      sprp_pkg::ST_PRE: begin
        if (sts.n_small || sts.both_even) begin
          res_nxt   = 1'b0;
          state_nxt = sprp_pkg::ST_DONE;
        end else begin
          state_nxt = sprp_pkg::ST_GCD;
        end
      end
      sprp_pkg::ST_GCD: begin
        if (sts.gcd_done) begin
          if (sts.coprime) begin
            state_nxt = sprp_pkg::ST_RED;
          end else begin
            res_nxt   = 1'b0;
            state_nxt = sprp_pkg::ST_DONE;
          end
        end else begin
          op = sprp_pkg::OP_GCD;
        end
      end
      sprp_pkg::ST_RED: begin
        op = sprp_pkg::OP_RED;
        if (sts.cnt_zero) begin
          state_nxt = sprp_pkg::ST_SPLIT;
        end
      end
      sprp_pkg::ST_SPLIT: begin
        if (sts.d_even) begin
          op = sprp_pkg::OP_SPLIT;
        end else begin
          op        = sprp_pkg::OP_EXP_INIT;
          state_nxt = sprp_pkg::ST_EXP_SQ;
        end
      end
      sprp_pkg::ST_EXP_SQ: begin
        op        = sprp_pkg::OP_SQ_X;
        state_nxt = sprp_pkg::ST_MUL_SQ;
      end
      sprp_pkg::ST_MUL_SQ: begin
        op = sprp_pkg::OP_MUL_STEP;
        if (sts.cnt_zero) begin
          state_nxt = sprp_pkg::ST_EXP_BIT;
        end
      end
      sprp_pkg::ST_EXP_BIT: begin
        if (sts.ebit) begin
          op        = sprp_pkg::OP_MUL_B;
          state_nxt = sprp_pkg::ST_MUL_B;
        end else begin
          state_nxt = sprp_pkg::ST_EXP_NEXT;
        end
      end
      sprp_pkg::ST_MUL_B: begin
        op = sprp_pkg::OP_MUL_STEP;
        if (sts.cnt_zero) begin
          state_nxt = sprp_pkg::ST_EXP_NEXT;
        end
      end
      sprp_pkg::ST_EXP_NEXT: begin
        if (sts.ecnt_zero) begin
          state_nxt = sprp_pkg::ST_CHECK;
        end else begin
          op        = sprp_pkg::OP_EBIT_DEC;
          state_nxt = sprp_pkg::ST_EXP_SQ;
        end
      end
      sprp_pkg::ST_CHECK, sprp_pkg::ST_CHECK_S: begin
        priority if (sts.x_nm1 || (state_r == sprp_pkg::ST_CHECK && sts.x_one)) begin
          res_nxt   = 1'b1;
          state_nxt = sprp_pkg::ST_DONE;
        end else if (sts.s_gt1) begin
          op        = sprp_pkg::OP_SQ_LOOP;
          state_nxt = sprp_pkg::ST_MUL_S;
        end else begin
          res_nxt   = 1'b0;
          state_nxt = sprp_pkg::ST_DONE;
        end
      end
      sprp_pkg::ST_MUL_S: begin
        op = sprp_pkg::OP_MUL_STEP;
        if (sts.cnt_zero) begin
          state_nxt = sprp_pkg::ST_CHECK_S;
        end
      end
      sprp_pkg::ST_DONE: begin
        if (slot_free) begin
          res_push  = 1'b1;
          state_nxt = sprp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sprp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/sprp_chk.sv
// Port-level checker for the strong probable prime test core.
// Bound to strong_probable_prime_test_core; no other dependencies.
module sprp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Drop ready after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // Keep padding bits zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'b0)
    else $error("nonzero padding on result");

  // Clear the result channel on reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind strong_probable_prime_test_core sprp_chk u_sprp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
